// ===== rtl/ulist_pkg.sv =====
package ulist_pkg;

  localparam int FUNC_W         = 3;
  localparam int POS_W          = 7;
  localparam int ITEM_W         = 32;
  localparam int STAT_W         = 2;
  localparam int COUNT_W        = 7;
  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_DATA_WIDTH = 32;

  typedef enum logic [FUNC_W-1:0] {
    F_APPEND      = 3'd0,
    F_INSERT      = 3'd1,
    F_REM_VALUE   = 3'd2,
    F_REM_LARGEST = 3'd3,
    F_UPDATE      = 3'd4,
    F_GET         = 3'd5,
    F_FIND        = 3'd6,
    F_CLEAR       = 3'd7
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

endpackage

// ===== rtl/ulist_ram.sv =====
module ulist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/unsorted_list_engine_unit.sv =====
// Unsorted list engine: a fixed-capacity list of signed words held in one
// single-port-read / single-port-write RAM, entries 0..count-1 valid. Each
// accepted transfer carries one operation (append, insert, remove value,
// remove largest, update, get, find, clear) and yields exactly one result
// transfer with status, found flag, value, count after the operation and the
// full/empty flags. Items are handled one at a time. Find and remove-by-value
// search the list reading one entry per cycle through the RAM read port;
// remove-largest makes one pass to find the maximum and one pass shifting
// later entries down, again one entry per cycle on the RAM ports. A new input
// transfer is taken as soon as the previous result sits in the output
// register, even while that result is still stalled downstream. No clearing
// pass after reset: only entries below count are ever used.
module unsorted_list_engine_unit #(
  parameter int CAPACITY   = ulist_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = ulist_pkg::DEF_DATA_WIDTH
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic        [ulist_pkg::FUNC_W-1:0]     func,
  input  logic        [ulist_pkg::POS_W-1:0]      position,
  input  logic signed [ulist_pkg::ITEM_W-1:0]     item_in,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic        [ulist_pkg::STAT_W-1:0]     status,
  output logic                                    found,
  output logic signed [ulist_pkg::ITEM_W-1:0]     item_out,
  output logic        [ulist_pkg::COUNT_W-1:0]    count,
  output logic                                    is_full,
  output logic                                    is_empty
);
  import ulist_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);          // holds 0..CAPACITY
  localparam int MW = (CW > POS_W) ? CW : POS_W;     // position vs count compare

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_INS_MOVE,
    S_INS_PUT,
    S_SCAN,
    S_RM_FILL,
    S_SHIFT,
    S_GET_RD,
    S_RESULT
  } state_t;

  state_t                  state;
  func_t                   op;
  logic [POS_W-1:0]        cpos;
  logic [DATA_WIDTH-1:0]   cval;
  logic [CW-1:0]           cnt;
  logic [CW-1:0]           rd_ptr;
  logic [CW-1:0]           cmp_ptr;
  logic                    cmp_vld;
  logic [DATA_WIDTH-1:0]   best_val;
  logic [CW-1:0]           best_idx;
  status_t                 res_status;
  logic                    res_found;
  logic [ITEM_W-1:0]       res_item;
  logic [CW-1:0]           out_cnt;

  // RAM ports
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [DATA_WIDTH-1:0]   ram_wdata;
  logic [AW-1:0]           ram_raddr;
  logic [DATA_WIDTH-1:0]   ram_rdata;

  logic [CW-1:0]           cnt_m1;
  logic [CW-1:0]           cmp_m1;
  logic [CW-1:0]           best_nidx;
  logic [DATA_WIDTH-1:0]   best_nval;
  logic                    is_full_i;
  logic                    pos_lt_n;
  logic                    pos_gt_n;
  logic                    issue;
  logic                    last;
  logic                    match;
  logic                    out_free;

  ulist_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cnt_m1    = cnt - 1'b1;
  assign cmp_m1    = cmp_ptr - 1'b1;
  assign is_full_i = (cnt == CW'(CAPACITY));
  assign pos_lt_n  = (MW'(cpos) < MW'(cnt));
  assign pos_gt_n  = (MW'(cpos) > MW'(cnt));
  assign issue     = (rd_ptr < cnt);
  assign last      = cmp_vld && (cmp_ptr == cnt_m1);
  assign match     = cmp_vld && (ram_rdata == cval);
  assign out_free  = !out_valid || !out_stall;

  // running maximum including the entry compared this cycle; ties keep the first
  always_comb begin
    if (cmp_ptr == '0 || $signed(ram_rdata) > $signed(best_val)) begin
      best_nval = ram_rdata;
      best_nidx = cmp_ptr;
    end else begin
      best_nval = best_val;
      best_nidx = best_idx;
    end
  end

  // RAM access per state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = cval;
    ram_raddr = '0;
    unique case (state)
      S_DISP: begin
        unique case (op)
          F_APPEND: begin
            ram_we    = !is_full_i;
            ram_waddr = cnt[AW-1:0];
          end
          F_INSERT: begin
            ram_we    = !is_full_i && (MW'(cpos) == MW'(cnt));
            ram_waddr = cnt[AW-1:0];
            ram_raddr = AW'(cpos);
          end
          F_UPDATE: begin
            ram_we    = pos_lt_n;
            ram_waddr = AW'(cpos);
          end
          F_GET: begin
            ram_raddr = AW'(cpos);
          end
          default: begin
          end
        endcase
      end
      S_INS_MOVE: begin
        // old occupant goes to the end
        ram_we    = 1'b1;
        ram_waddr = cnt[AW-1:0];
        ram_wdata = ram_rdata;
      end
      S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(cpos);
      end
      S_SCAN: begin
        if (issue) begin
          ram_raddr = rd_ptr[AW-1:0];
        end
        // hit on remove-by-value: fetch the last entry to fill the hole
        if (match && op == F_REM_VALUE) begin
          ram_raddr = cnt_m1[AW-1:0];
        end
      end
      S_RM_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = best_idx[AW-1:0];
        ram_wdata = ram_rdata;
      end
      S_SHIFT: begin
        if (issue) begin
          ram_raddr = rd_ptr[AW-1:0];
        end
        ram_we    = cmp_vld;
        ram_waddr = cmp_m1[AW-1:0];
        ram_wdata = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  assign in_stall = rst || (state != S_IDLE);
  assign count    = COUNT_W'(out_cnt);
  assign is_full  = (out_cnt == CW'(CAPACITY));
  assign is_empty = (out_cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      cmp_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= func_t'(func);
            cpos  <= position;
            cval  <= DATA_WIDTH'(item_in);
            state <= S_DISP;
          end
        end
        S_DISP: begin
          res_status <= ST_OK;
          res_found  <= 1'b0;
          res_item   <= '0;
          rd_ptr     <= '0;
          cmp_vld    <= 1'b0;
          state      <= S_RESULT;
          unique case (op) inside
            F_APPEND: begin
              if (is_full_i) begin
                res_status <= ST_FULL;
              end else begin
                cnt <= cnt + 1'b1;
              end
            end
            F_INSERT: begin
              if (is_full_i) begin
                res_status <= ST_FULL;
              end else if (pos_gt_n) begin
                res_status <= ST_BADPOS;
              end else if (pos_lt_n) begin
                state <= S_INS_MOVE;
              end else begin
                cnt <= cnt + 1'b1;
              end
            end
            F_REM_VALUE, F_REM_LARGEST: begin
              if (cnt == '0) begin
                res_status <= ST_EMPTY;
              end else begin
                state <= S_SCAN;
              end
            end
            F_UPDATE: begin
              if (!pos_lt_n) begin
                res_status <= ST_BADPOS;
              end
            end
            F_GET: begin
              if (!pos_lt_n) begin
                res_status <= ST_BADPOS;
                res_item   <= '1;
              end else begin
                state <= S_GET_RD;
              end
            end
            F_FIND: begin
              if (cnt != '0) begin
                state <= S_SCAN;
              end
            end
            F_CLEAR: begin
              cnt <= '0;
            end
          endcase
        end
        S_INS_MOVE: begin
          state <= S_INS_PUT;
        end
        S_INS_PUT: begin
          cnt   <= cnt + 1'b1;
          state <= S_RESULT;
        end
        S_GET_RD: begin
          res_item <= ITEM_W'(ram_rdata);
          state    <= S_RESULT;
        end
        S_SCAN: begin
          if (issue) begin
            rd_ptr  <= rd_ptr + 1'b1;
            cmp_ptr <= rd_ptr;
          end
          cmp_vld <= issue;
          if (op == F_REM_LARGEST) begin
            if (cmp_vld) begin
              best_val <= best_nval;
              best_idx <= best_nidx;
            end
            if (last) begin
              res_item <= ITEM_W'($signed(best_nval));
              if (best_nidx == cnt_m1) begin
                cnt   <= cnt_m1;
                state <= S_RESULT;
              end else begin
                rd_ptr  <= best_nidx + 1'b1;
                cmp_vld <= 1'b0;
                state   <= S_SHIFT;
              end
            end
          end else if (match) begin
            res_found <= 1'b1;
            best_idx  <= cmp_ptr;
            state     <= (op == F_REM_VALUE) ? S_RM_FILL : S_RESULT;
          end else if (last) begin
            state <= S_RESULT;
          end
        end
        S_RM_FILL: begin
          cnt   <= cnt_m1;
          state <= S_RESULT;
        end
        S_SHIFT: begin
          if (issue) begin
            rd_ptr  <= rd_ptr + 1'b1;
            cmp_ptr <= rd_ptr;
          end
          cmp_vld <= issue;
          if (last) begin
            cnt     <= cnt_m1;
            cmp_vld <= 1'b0;
            state   <= S_RESULT;
          end
        end
        S_RESULT: begin
          cmp_vld <= 1'b0;
          if (out_free) begin
            out_valid <= 1'b1;
            status    <= res_status;
            found     <= res_found;
            item_out  <= res_item;
            out_cnt   <= cnt;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // count stays within capacity
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // a compared entry always lies inside the valid range
  a_cmp_in_range: assert property (@(posedge clk) disable iff (rst)
    cmp_vld && (state == S_SCAN || state == S_SHIFT) |-> cmp_ptr < cnt)
    else $error("compare pointer beyond count");

  // a finished result moves out once the output register is free
  a_result_moves: assert property (@(posedge clk) disable iff (rst)
    state == S_RESULT && out_free |=> out_valid && state == S_IDLE)
    else $error("result not loaded into output register");

  // a full status is only reported with a full list
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> is_full)
    else $error("full status without full list");

endmodule

// ===== tb/unsorted_list_engine_unit_test.sv =====
`timescale 1ns / 1ps
module unsorted_list_engine_unit_test;
  import ulist_pkg::*;

  localparam int CAP          = DEF_CAPACITY;
  localparam int ITEM_TARGET  = 1150;
  // Covers the slowest item, remove-largest at full, plus stall bursts
  // and the one long receiver hold-off; this only trips on a real hang.
  localparam int QUIET_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AT_ITEM = 300;
  localparam int DRAIN_CYCLES = 300;
  localparam int PRINT_CAP    = 100;

  // One list operation as it crosses the input channel.
  typedef struct {
    func_t                    op;
    logic [POS_W-1:0]         pos;
    logic signed [ITEM_W-1:0] val;
  } list_cmd_t;

  // One result as it should come back on the output channel.
  typedef struct {
    status_t                  st;
    logic                     hit;
    logic signed [ITEM_W-1:0] value;
    logic [COUNT_W-1:0]       cnt;
    logic                     full;
    logic                     empty;
  } list_resp_t;

  // DUT ports; every input starts at a known value.
  logic                     clk      = 1'b0;
  logic                     rst      = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [FUNC_W-1:0]        func     = '0;
  logic [POS_W-1:0]         position = '0;
  logic signed [ITEM_W-1:0] item_in  = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [STAT_W-1:0]        status;
  logic                     found;
  logic signed [ITEM_W-1:0] item_out;
  logic [COUNT_W-1:0]       count;
  logic                     is_full;
  logic                     is_empty;

  unsorted_list_engine_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .position  (position),
    .item_in   (item_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .found     (found),
    .item_out  (item_out),
    .count     (count),
    .is_full   (is_full),
    .is_empty  (is_empty)
  );

  always #5 clk = ~clk;

  // Operations waiting to be offered, and results owed by the block.
  list_cmd_t  op_queue[$];
  list_resp_t answer_queue[$];

  // Predictor state: our own copy of the list contents and length.
  logic signed [ITEM_W-1:0] list_words [CAP];
  int                       list_len = 0;

  int  mismatches  = 0;
  int  items_taken = 0;
  int  results_seen = 0;
  int  quiet_cycles = 0;
  bit  op_taken    = 1'b0;   // set at the edge that accepts a transfer
  int  gap_left    = 0;
  int  stall_left  = 0;
  int  hold_left   = 0;
  bit  hold_done   = 1'b0;
  list_cmd_t  next_cmd;
  list_resp_t want_resp;

  // Applies one operation to the predicted list and returns its result.
  function automatic list_resp_t apply_list_op(list_cmd_t c);
    list_resp_t r;
    int         n;
    int         p;
    int         best;
    n       = list_len;
    p       = c.pos;
    r.st    = ST_OK;
    r.hit   = 1'b0;
    r.value = '0;
    case (c.op)
      F_APPEND: begin
        if (n >= CAP) begin
          r.st = ST_FULL;
        end else begin
          list_words[n] = c.val;
          list_len      = n + 1;
        end
      end
      F_INSERT: begin
        // old occupant moves to the end; insert at count is a plain append
        if (n >= CAP) begin
          r.st = ST_FULL;
        end else if (p > n) begin
          r.st = ST_BADPOS;
        end else begin
          if (p < n) list_words[n] = list_words[p];
          list_words[p] = c.val;
          list_len      = n + 1;
        end
      end
      F_REM_VALUE: begin
        // first match only; last entry fills the hole
        if (n == 0) begin
          r.st = ST_EMPTY;
        end else begin
          for (int i = 0; i < n && !r.hit; i++) begin
            if (list_words[i] == c.val) begin
              list_words[i] = list_words[n-1];
              list_len      = n - 1;
              r.hit         = 1'b1;
            end
          end
        end
      end
      F_REM_LARGEST: begin
        // lowest index wins a tie; later entries shift down in order
        if (n == 0) begin
          r.st = ST_EMPTY;
        end else begin
          best = 0;
          for (int i = 1; i < n; i++) begin
            if (list_words[i] > list_words[best]) best = i;
          end
          r.value = list_words[best];
          for (int i = best; i < n - 1; i++) list_words[i] = list_words[i+1];
          list_len = n - 1;
        end
      end
      F_UPDATE: begin
        if (p >= n) r.st = ST_BADPOS;
        else list_words[p] = c.val;
      end
      F_GET: begin
        if (p >= n) begin
          r.st    = ST_BADPOS;
          r.value = -1;
        end else begin
          r.value = list_words[p];
        end
      end
      F_FIND: begin
        for (int i = 0; i < n && !r.hit; i++) begin
          if (list_words[i] == c.val) r.hit = 1'b1;
        end
      end
      F_CLEAR: begin
        list_len = 0;
      end
    endcase
    r.cnt   = list_len[COUNT_W-1:0];
    r.full  = (list_len == CAP);
    r.empty = (list_len == 0);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("%0t ns: result %0d: %s", $time, results_seen, msg);
    mismatches++;
  endtask

  function automatic void queue_cmd(input func_t op, input int pos,
                                    input logic signed [ITEM_W-1:0] v);
    list_cmd_t c;
    c.op  = op;
    c.pos = pos[POS_W-1:0];
    c.val = v;
    op_queue.push_back(c);
  endfunction

  // Data values lean on the extremes and on a narrow band so that ties and
  // repeated values show up in the largest search and in the matches.
  function automatic logic signed [ITEM_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return {1'b1, {(ITEM_W-1){1'b0}}};
      1:       return {1'b0, {(ITEM_W-1){1'b1}}};
      2, 3:    return $signed($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  // Idling stops for every fourth stretch of 100 transfers and in the tail.
  function automatic bit idling_allowed();
    return !(((items_taken / 100) % 4) == 3 || op_queue.size() < 150);
  endfunction

  // Sender: new payload at the falling edge once the previous transfer is
  // done; a held item keeps valid and payload untouched.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !op_taken) begin
      // still waiting on the current transfer
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
      gap_left = $urandom_range(1, 15) - 1;
      in_valid <= 1'b0;
    end else if (op_queue.size() > 0) begin
      next_cmd = op_queue.pop_front();
      func     <= next_cmd.op;
      position <= next_cmd.pos;
      item_in  <= next_cmd.val;
      in_valid <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
    op_taken = 1'b0;
  end

  // Receiver: random stall bursts, plus one long hold-off that lets the
  // block back up and push stall onto the sender.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && items_taken >= HOLD_AT_ITEM) begin
      hold_left = HOLD_CYCLES - 1;
      hold_done = 1'b1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idling_allowed() && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Rising edge: check the result transfer first, then predict for the
  // input transfer, so the queue order never depends on process order.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (answer_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer, status %0d count %0d",
                                    status, count));
        end else begin
          want_resp = answer_queue.pop_front();
          if (status !== want_resp.st)
            report_mismatch($sformatf("status %0d, want %0d", status, want_resp.st));
          if (found !== want_resp.hit)
            report_mismatch($sformatf("found %0b, want %0b", found, want_resp.hit));
          if (item_out !== want_resp.value)
            report_mismatch($sformatf("item_out %0d, want %0d", item_out, want_resp.value));
          if (count !== want_resp.cnt)
            report_mismatch($sformatf("count %0d, want %0d", count, want_resp.cnt));
          if (is_full !== want_resp.full)
            report_mismatch($sformatf("is_full %0b, want %0b", is_full, want_resp.full));
          if (is_empty !== want_resp.empty)
            report_mismatch($sformatf("is_empty %0b, want %0b", is_empty, want_resp.empty));
        end
        results_seen++;
      end
      if (in_valid && !in_stall) begin
        next_cmd.op  = func_t'(func);
        next_cmd.pos = position;
        next_cmd.val = item_in;
        answer_queue.push_back(apply_list_op(next_cmd));
        op_taken = 1'b1;
        items_taken++;
      end
      // watchdog: cycles without any transfer on either side
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int est;
    int fill_len;
    int body_len;
    int pos;
    int top;
    func_t op;
    logic signed [ITEM_W-1:0] v;
    logic signed [ITEM_W-1:0] val_pool[$];

    // Directed: empty-list errors, insert at count, value extremes, bad
    // positions, hit and miss searches, tie on the largest, clear.
    queue_cmd(F_CLEAR,       0,   0);
    queue_cmd(F_REM_VALUE,   0,   5);                  // empty list
    queue_cmd(F_REM_LARGEST, 0,   0);                  // empty list
    queue_cmd(F_GET,         0,   0);                  // bad get reads -1
    queue_cmd(F_UPDATE,      0,   9);                  // bad position
    queue_cmd(F_INSERT,      1,   3);                  // position above count
    queue_cmd(F_INSERT,      0,   32'sh7fff_ffff);     // insert at count
    queue_cmd(F_APPEND,      127, 32'sh8000_0000);
    queue_cmd(F_APPEND,      0,   0);
    queue_cmd(F_APPEND,      0,   -1);
    queue_cmd(F_INSERT,      1,   77);                 // occupant moves to end
    queue_cmd(F_GET,         1,   0);
    queue_cmd(F_GET,         127, 0);                  // far out of range
    queue_cmd(F_UPDATE,      5,   1);                  // position equals count
    queue_cmd(F_UPDATE,      2,   32'sh5555_5555);
    queue_cmd(F_FIND,        0,   -1);                 // hit
    queue_cmd(F_FIND,        0,   1234);               // miss
    queue_cmd(F_REM_VALUE,   0,   999);                // miss
    queue_cmd(F_REM_VALUE,   0,   77);                 // hit, last fills slot
    queue_cmd(F_APPEND,      0,   32'sh7fff_ffff);     // tie with the first
    queue_cmd(F_REM_LARGEST, 0,   0);
    queue_cmd(F_REM_LARGEST, 0,   0);
    queue_cmd(F_REM_LARGEST, 0,   0);
    queue_cmd(F_CLEAR,       0,   0);
    queue_cmd(F_GET,         0,   0);                  // read after clear

    // Random: mostly well-formed sequences (optional clear, a fill, then a
    // body that targets live slots and stored values); a rough count estimate
    // keeps positions mostly in range. The rest is unconstrained noise.
    est = 0;
    while (op_queue.size() < ITEM_TARGET) begin
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 3) != 0) begin
          queue_cmd(F_CLEAR, $urandom_range(0, 127), $urandom);
          est = 0;
        end
        // now and then fill to capacity and past it
        fill_len = ($urandom_range(0, 7) == 0) ? CAP + 2 : $urandom_range(0, 12);
        for (int i = 0; i < fill_len; i++) begin
          v = pick_value();
          queue_cmd(F_APPEND, $urandom_range(0, 127), v);
          if (est < CAP) est++;
          val_pool.push_back(v);
          if (val_pool.size() > 16) void'(val_pool.pop_front());
        end
        body_len = $urandom_range(5, 25);
        for (int i = 0; i < body_len; i++) begin
          op  = func_t'($urandom_range(0, 6));
          v   = (val_pool.size() > 0 && $urandom_range(0, 1) == 1) ?
                val_pool[$urandom_range(0, val_pool.size() - 1)] : pick_value();
          top = (op == F_INSERT) ? est : ((est > 0) ? est - 1 : 0);
          pos = ($urandom_range(0, 5) != 0) ? $urandom_range(0, top) : $urandom_range(0, 127);
          queue_cmd(op, pos, v);
          case (op) inside
            F_APPEND: if (est < CAP) est++;
            F_INSERT: if (est < CAP && pos <= est) est++;
            F_REM_VALUE, F_REM_LARGEST: if (est > 0) est--;
            default: ;
          endcase
          if (op == F_APPEND || op == F_INSERT) begin
            val_pool.push_back(v);
            if (val_pool.size() > 16) void'(val_pool.pop_front());
          end
        end
      end else begin
        body_len = $urandom_range(5, 15);
        for (int i = 0; i < body_len; i++)
          queue_cmd(func_t'($urandom_range(0, 7)), $urandom_range(0, 127), $urandom);
      end
    end

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Drain: everything offered, accepted and answered, then a quiet tail
    // so a stray extra result still gets caught.
    while (op_queue.size() > 0 || in_valid || answer_queue.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ulist_pkg.sv
rtl/ulist_ram.sv
rtl/unsorted_list_engine_unit.sv
tb/unsorted_list_engine_unit_test.sv
